// ===== design/led_breathe_alert_strip_unit_defines.svh =====
// ----------------------------------------------------------------------------
// led breathe alert strip: assertion macros
// shared concurrent assertion forms, clocked on clk, one disabled by arst_n
// ----------------------------------------------------------------------------
`ifndef LED_BREATHE_ALERT_STRIP_UNIT_DEFINES_SVH
`define LED_BREATHE_ALERT_STRIP_UNIT_DEFINES_SVH

// checked outside reset only
`define LBAS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define LBAS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/lbas_pkg.sv =====
// ----------------------------------------------------------------------------
// lbas_pkg
// types and constants of the led breathe alert strip
// ----------------------------------------------------------------------------
`default_nettype none

package lbas_pkg;

	// widths of the shared divider and multiplier
	localparam int DIVIDEND_W = 32;
	localparam int DIVISOR_W  = 27;
	localparam int STEP_W     = 6;
	localparam int MUL_W      = 17;

	// arithmetic constants
	localparam int SCALE_MS       = 1600;
	localparam int BASE_PERIOD    = 400;
	localparam int SETUP_PERIOD   = 3000;
	localparam int VISIBLE_PERIOD = 4000;
	localparam int FLOOR_Q16      = 9830;
	localparam int SPAN_Q16       = 55706;
	localparam int ONE_Q17        = 131072;
	localparam int ROUND_Q16      = 32768;
	localparam int FRAC_STEPS     = 17;
	localparam int FULL_STEPS     = 32;

	// command codes
	typedef enum logic [1:0] {
		CMD_BLIP   = 2'd0,
		CMD_EVENT  = 2'd1,
		CMD_FINISH = 2'd2
	} lbas_cmd_t;

	// register indexes
	typedef enum logic [2:0] {
		REG_SETUP_COLOR   = 3'd0,
		REG_VISIBLE_COLOR = 3'd1,
		REG_ALERT_COLOR   = 3'd2,
		REG_ALERT_WINDOW  = 3'd3,
		REG_STAGE_TWO     = 3'd4,
		REG_STAGE_THREE   = 3'd5
	} lbas_reg_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_PERIOD,
		ST_DIV_MOD,
		ST_DIV_FRAC,
		ST_SPAN,
		ST_RED,
		ST_GREEN,
		ST_BLUE,
		ST_EMIT
	} lbas_state_t;

	typedef struct packed {
		logic [1:0]        command;
		logic              entry_visible;
		logic signed [31:0] starts_in;
		logic              needs_setup;
		logic [31:0]       phase_ms;
	} lbas_item_t;

	typedef struct packed {
		logic [2:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} lbas_pixel_t;

	typedef struct packed {
		logic                  start;
		logic [DIVISOR_W-1:0]  rem_init;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
		logic [STEP_W-1:0]     steps;
	} lbas_div_req_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [DIVIDEND_W-1:0] quot;
		logic [DIVISOR_W-1:0]  rem;
	} lbas_div_rsp_t;

endpackage

`default_nettype wire

// ===== design/lbas_div.sv =====
// ----------------------------------------------------------------------------
// lbas_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_breathe_alert_strip_unit_defines.svh"

module lbas_div
	import lbas_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lbas_div_req_t req,
	output lbas_div_rsp_t      rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] acc_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, acc_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			acc_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			acc_q <= {acc_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = acc_q;
	assign rsp.rem  = rem_q;

	`LBAS_ASSERT(a_div_start_idle, req.start |-> !busy_q, "divider started while busy")
	`LBAS_ASSERT(a_div_start_busy, req.start |=> busy_q, "divider did not run after start")
	`LBAS_ASSERT_ALWAYS(a_div_done_idle, done_q |-> !busy_q, "divider done while busy")

endmodule

`default_nettype wire

// ===== design/led_breathe_alert_strip_unit.sv =====
// ----------------------------------------------------------------------------
// led_breathe_alert_strip_unit
// snapshot accumulator and breathing color sequencer for an led strip
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  item    | item_valid, item_stall, item         | in, beat per snapshot entry
//  pixel   | pixel_valid, pixel_stall, pixel      | out, beat per strip pixel
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | in, register write
//
//  blip and event beats do not leave idle; item_stall stays low.
//  a finish beat with setup, blip or alert uses the divider (one quotient
//  bit per cycle) for the period (alert, nonzero window), phase modulo
//  period and fraction, multiplies span, red, green, blue; then PIXELS beats.
//  item_stall is high from the finish beat until the last pixel is loaded
//  into the output register; pixel_stall holds that register.
//  arst_n clears the sequencer and accumulators and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_breathe_alert_strip_unit_defines.svh"

module led_breathe_alert_strip_unit
	import lbas_pkg::*;
#(
	parameter int PIXELS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire lbas_item_t  item,
	output logic             pixel_valid,
	input  wire logic        pixel_stall,
	output lbas_pixel_t      pixel,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int PIX_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int LIT_W   = $clog2(PIXELS + 1);
	localparam int LIT_TWO = (PIXELS < 2) ? PIXELS : 2;

	// configuration registers
	logic [23:0] setup_color_q;
	logic [23:0] visible_color_q;
	logic [23:0] alert_color_q;
	logic [15:0] window_q;
	logic [15:0] stage_two_q;
	logic [15:0] stage_three_q;

	// snapshot accumulators
	logic        saw_blip_q;
	logic        alert_found_q;
	logic [15:0] soonest_q;

	// finish working registers
	lbas_state_t          state_q, state_d;
	logic [31:0]          phase_q;
	logic [DIVISOR_W-1:0] period_q;
	logic                 half_q;
	logic [MUL_W-1:0]     tri_q;
	logic [MUL_W-1:0]     br_q;
	logic [23:0]          color_q;
	logic [LIT_W-1:0]     lit_q;
	logic [7:0]           red_q;
	logic [7:0]           green_q;
	logic [7:0]           blue_q;
	logic [PIX_W-1:0]     pix_q;
	logic                 pixel_valid_q;
	lbas_pixel_t          pixel_q;

	logic                 item_fire;
	logic                 finish_fire;
	logic                 in_window;
	logic                 pixel_load;
	logic                 last_pix;
	logic                 pix_on;
	logic [MUL_W-1:0]     mul_a;
	logic [MUL_W-1:0]     mul_b;
	logic [2*MUL_W-1:0]   product;
	logic [2*MUL_W-1:0]   rounded;
	logic [7:0]           channel;
	logic [DIVISOR_W-1:0] alert_period;
	logic [MUL_W:0]       tri_down;
	lbas_div_req_t        div_req;
	lbas_div_rsp_t        div_rsp;

	assign item_stall  = (state_q != ST_IDLE);
	assign item_fire   = item_valid && !item_stall;
	assign finish_fire = item_fire && (item.command == CMD_FINISH);
	assign cfg_ready   = 1'b1;

	assign in_window = item.entry_visible && !item.starts_in[31]
		&& (item.starts_in[30:16] == '0) && (item.starts_in[15:0] <= window_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_color_q   <= 24'hFF8000;
			visible_color_q <= 24'h00FFFF;
			alert_color_q   <= 24'hFF0000;
			window_q        <= 16'd900;
			stage_two_q     <= 16'd300;
			stage_three_q   <= 16'd60;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SETUP_COLOR:   setup_color_q   <= cfg_data;
				REG_VISIBLE_COLOR: visible_color_q <= cfg_data;
				REG_ALERT_COLOR:   alert_color_q   <= cfg_data;
				REG_ALERT_WINDOW:  window_q        <= cfg_data[15:0];
				REG_STAGE_TWO:     stage_two_q     <= cfg_data[15:0];
				REG_STAGE_THREE:   stage_three_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// snapshot accumulation, cleared by finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saw_blip_q    <= 1'b0;
			alert_found_q <= 1'b0;
			soonest_q     <= '0;
		end else if (item_fire) begin
			unique case (item.command)
				CMD_BLIP: begin
					if (item.entry_visible) begin
						saw_blip_q <= 1'b1;
					end
				end
				CMD_EVENT: begin
					if (in_window && (!alert_found_q || (item.starts_in[15:0] < soonest_q))) begin
						alert_found_q <= 1'b1;
						soonest_q     <= item.starts_in[15:0];
					end
				end
				CMD_FINISH: begin
					saw_blip_q    <= 1'b0;
					alert_found_q <= 1'b0;
					soonest_q     <= '0;
				end
				default: ;
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				mul_a = MUL_W'(SCALE_MS);
				mul_b = {1'b0, soonest_q};
			end
			ST_SPAN: begin
				mul_a = MUL_W'(SPAN_Q16);
				mul_b = tri_q;
			end
			ST_RED: begin
				mul_a = {9'd0, color_q[23:16]};
				mul_b = br_q;
			end
			ST_GREEN: begin
				mul_a = {9'd0, color_q[15:8]};
				mul_b = br_q;
			end
			ST_BLUE: begin
				mul_a = {9'd0, color_q[7:0]};
				mul_b = br_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		product = mul_a * mul_b;
		rounded = product + (2*MUL_W)'(ROUND_Q16);
		channel = (rounded[2*MUL_W-1:24] != '0) ? 8'hFF : rounded[23:16];
	end

	assign alert_period = DIVISOR_W'(BASE_PERIOD) + div_rsp.quot[DIVISOR_W-1:0];
	assign tri_down     = (MUL_W+1)'(ONE_Q17) - {1'b0, div_rsp.quot[MUL_W-1:0]};

	// output register handshake
	assign pixel_load = (state_q == ST_EMIT) && (!pixel_valid_q || !pixel_stall);
	assign last_pix   = (pix_q == PIX_W'(PIXELS - 1));
	assign pix_on     = (LIT_W'(pix_q) < lit_q);

	// sequencer: next state and divider requests
	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.rem_init = '0;
		div_req.dividend = phase_q;
		div_req.divisor  = period_q;
		div_req.steps    = STEP_W'(FULL_STEPS);
		unique case (state_q)
			ST_IDLE: begin
				if (finish_fire) begin
					div_req.dividend = item.phase_ms;
					priority if (item.needs_setup) begin
						div_req.start   = 1'b1;
						div_req.divisor = DIVISOR_W'(SETUP_PERIOD);
						state_d         = ST_DIV_MOD;
					end else if (saw_blip_q) begin
						div_req.start   = 1'b1;
						div_req.divisor = DIVISOR_W'(VISIBLE_PERIOD);
						state_d         = ST_DIV_MOD;
					end else if (alert_found_q && (window_q == '0)) begin
						div_req.start   = 1'b1;
						div_req.divisor = DIVISOR_W'(BASE_PERIOD);
						state_d         = ST_DIV_MOD;
					end else if (alert_found_q) begin
						div_req.start    = 1'b1;
						div_req.dividend = product[DIVIDEND_W-1:0];
						div_req.divisor  = {{(DIVISOR_W-16){1'b0}}, window_q};
						state_d          = ST_DIV_PERIOD;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_DIV_PERIOD: begin
				if (div_rsp.done) begin
					div_req.start   = 1'b1;
					div_req.divisor = alert_period;
					state_d         = ST_DIV_MOD;
				end
			end
			ST_DIV_MOD: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.rem_init = div_rsp.rem;
					div_req.dividend = '0;
					div_req.steps    = STEP_W'(FRAC_STEPS);
					state_d          = ST_DIV_FRAC;
				end
			end
			ST_DIV_FRAC: begin
				if (div_rsp.done) begin
					state_d = ST_SPAN;
				end
			end
			ST_SPAN:  state_d = ST_RED;
			ST_RED:   state_d = ST_GREEN;
			ST_GREEN: state_d = ST_BLUE;
			ST_BLUE:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (pixel_load && last_pix) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// finish working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (finish_fire) begin
					phase_q <= item.phase_ms;
					red_q   <= '0;
					green_q <= '0;
					blue_q  <= '0;
					priority if (item.needs_setup) begin
						color_q  <= setup_color_q;
						lit_q    <= LIT_W'(PIXELS);
						period_q <= DIVISOR_W'(SETUP_PERIOD);
					end else if (saw_blip_q) begin
						color_q  <= visible_color_q;
						lit_q    <= LIT_W'(PIXELS);
						period_q <= DIVISOR_W'(VISIBLE_PERIOD);
					end else if (alert_found_q) begin
						color_q  <= alert_color_q;
						period_q <= DIVISOR_W'(BASE_PERIOD);
						priority if (soonest_q > stage_two_q) begin
							lit_q <= LIT_W'(1);
						end else if (soonest_q > stage_three_q) begin
							lit_q <= LIT_W'(LIT_TWO);
						end else begin
							lit_q <= LIT_W'(PIXELS);
						end
					end else begin
						color_q <= '0;
						lit_q   <= '0;
					end
				end
			end
			ST_DIV_PERIOD: begin
				if (div_rsp.done) begin
					period_q <= alert_period;
				end
			end
			ST_DIV_MOD: begin
				if (div_rsp.done) begin
					half_q <= ({div_rsp.rem, 1'b0} < {1'b0, period_q});
				end
			end
			ST_DIV_FRAC: begin
				if (div_rsp.done) begin
					tri_q <= half_q ? div_rsp.quot[MUL_W-1:0] : tri_down[MUL_W-1:0];
				end
			end
			ST_SPAN:  br_q    <= MUL_W'(FLOOR_Q16) + product[2*MUL_W-2:16];
			ST_RED:   red_q   <= channel;
			ST_GREEN: green_q <= channel;
			ST_BLUE:  blue_q  <= channel;
			ST_EMIT: ;
			default: ;
		endcase
	end

	// pixel counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q         <= '0;
			pixel_valid_q <= 1'b0;
		end else begin
			if (finish_fire) begin
				pix_q <= '0;
			end else if (pixel_load) begin
				pix_q <= pix_q + PIX_W'(1);
			end
			if (pixel_load) begin
				pixel_valid_q <= 1'b1;
			end else if (!pixel_stall) begin
				pixel_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_load) begin
			pixel_q.pixel_index <= 3'(pix_q);
			pixel_q.red         <= pix_on ? red_q : 8'd0;
			pixel_q.green       <= pix_on ? green_q : 8'd0;
			pixel_q.blue        <= pix_on ? blue_q : 8'd0;
			pixel_q.last        <= last_pix;
		end
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

	lbas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	`LBAS_ASSERT(a_finish_stalls, finish_fire |=> item_stall, "finish beat did not start the sequencer")
	`LBAS_ASSERT(a_done_in_div, div_rsp.done |-> (state_q == ST_DIV_PERIOD || state_q == ST_DIV_MOD || state_q == ST_DIV_FRAC), "divider result outside a divide step")
	`LBAS_ASSERT(a_idle_after_last, (state_q == ST_IDLE && $past(state_q) == ST_EMIT) |-> (pixel_valid && pixel.last), "strip ended without its last pixel")

endmodule

`default_nettype wire
